[rtl/lrfe_pkg.sv]
// Shared types, constants and the cosine table of the LED fade engine.
package lrfe_pkg;

  // Item operations.
  localparam logic OP_INIT = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_MAX    = 3'd4;

  localparam logic [7:0]  RST_CEILING    = 8'd255;
  localparam logic [9:0]  RST_LEVEL_LOW  = 10'd50;
  localparam logic [9:0]  RST_LEVEL_HIGH = 10'd300;
  localparam logic [15:0] RST_DUR_MIN    = 16'd1000;
  localparam logic [15:0] RST_DUR_MAX    = 16'd3000;

  // Level draw arithmetic.
  localparam logic [9:0]  PERMILLE_MAX = 10'd1000;
  localparam logic [13:0] FRAC_MAX     = 14'd10000;
  localparam logic [23:0] LVL_SCALE    = 24'd10000;
  localparam logic [31:0] LVL_ROUND    = 32'd5_000_000;
  // Ten million is 2^7 times 78125: shift by 7, then multiply by ceil(2^42 / 78125).
  // The error stays below one unit for every scaled value under 2^25.
  localparam int          LVL_PRE_SH   = 7;
  localparam int          LVL_RCP_SH   = 42;
  localparam logic [25:0] LVL_RCP      = 26'd56294996;

  // Easing arithmetic in Q1.16.
  localparam int          EASE_Q_W = 17;
  localparam logic [16:0] Q16_ONE  = 17'h10000;
  localparam logic [16:0] Q16_HALF = 17'h08000;

  localparam int CNT_W = 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_LV_NUM,
    S_LV_SCL,
    S_LV_DIV,
    S_LV_WB,
    S_UPDATE,
    S_EASE_INIT,
    S_EASE_DIV,
    S_COS1,
    S_COS2,
    S_MIX1,
    S_MIX2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rec_load;
    logic take_to;
    logic lv_num;
    logic lv_scl;
    logic lv_div;
    logic lv_wb;
    logic lv_from;
    logic update;
    logic ease_init;
    logic ease_div;
    logic cos1;
    logic cos2;
    logic mix1;
    logic mix2;
    logic zero_res;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic is_init;
    logic expired;
  } dp_status_t;

  typedef struct packed {
    logic [7:0]  from_level;
    logic [7:0]  to_level;
    logic [31:0] fade_start_ms;
    logic [15:0] fade_length_ms;
  } led_rec_t;

  // cos(k*pi/32) in Q1.16 for k = 0..16; zero beyond.
  function automatic logic [16:0] cos_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd65220;
      5'd2:    v = 17'd64277;
      5'd3:    v = 17'd62714;
      5'd4:    v = 17'd60547;
      5'd5:    v = 17'd57798;
      5'd6:    v = 17'd54491;
      5'd7:    v = 17'd50660;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd41576;
      5'd10:   v = 17'd36410;
      5'd11:   v = 17'd30893;
      5'd12:   v = 17'd25080;
      5'd13:   v = 17'd19024;
      5'd14:   v = 17'd12785;
      5'd15:   v = 17'd6424;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/led_random_fade_engine.sv]
// Random LED fade engine: top level joining the sequencer and the datapath.
//
// Each LED keeps a fade record (start level, target level, start time, length)
// in an internal memory of LED_COUNT entries, which holds no defined value until
// an init item has seeded that LED. One item is worked on at a time. A step item
// that needs no redraw reads the record and eases; a step that starts a new fade
// first draws a new target level, and an init item draws both the start and the
// target level; an item whose LED index is not below LED_COUNT returns 0. The
// easing uses the elapsed-by-length divider, and every level drawn is formed,
// scaled and divided by ten million with a reciprocal multiply, then written
// back. The result sits in an output register, so the next item can be taken
// while the previous result waits.
module led_random_fade_engine #(
  parameter int LED_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [5:0]  in_led_index,
  input  logic [31:0] in_now_ms,
  input  logic [13:0] in_rand_fraction,
  input  logic [13:0] in_rand_fraction_start,
  input  logic [15:0] in_rand_duration,
  input  logic [15:0] in_rand_phase,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_brightness
);

  lrfe_pkg::ctrl_cmd_t  cmd;
  lrfe_pkg::dp_status_t status;

  lrfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lrfe_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_operation           (in_operation),
    .in_led_index           (in_led_index),
    .in_now_ms              (in_now_ms),
    .in_rand_fraction       (in_rand_fraction),
    .in_rand_fraction_start (in_rand_fraction_start),
    .in_rand_duration       (in_rand_duration),
    .in_rand_phase          (in_rand_phase),
    .cmd                    (cmd),
    .status                 (status),
    .out_brightness         (out_brightness)
  );

endmodule

[rtl/lrfe_ctrl.sv]
// Sequencer of the LED fade engine: handshakes, step counting and datapath commands.
module lrfe_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  lrfe_pkg::dp_status_t   status,
  output lrfe_pkg::ctrl_cmd_t    cmd
);

  lrfe_pkg::state_t             state_r, state_nxt;
  logic [lrfe_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         pass_from_r, pass_from_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrfe_pkg::S_IDLE;
      cnt_r       <= '0;
      pass_from_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_from_r <= pass_from_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state, step counter and draw pass.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_from_nxt = pass_from_r;
    unique case (state_r)
      lrfe_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lrfe_pkg::S_READ;
      end
      lrfe_pkg::S_READ: state_nxt = lrfe_pkg::S_CHECK;
      lrfe_pkg::S_CHECK: begin
        priority if (!status.idx_ok) begin
          state_nxt = lrfe_pkg::S_DONE;
        end else if (status.is_init) begin
          pass_from_nxt = 1'b1;
          state_nxt     = lrfe_pkg::S_LV_NUM;
        end else if (status.expired) begin
          pass_from_nxt = 1'b0;
          state_nxt     = lrfe_pkg::S_LV_NUM;
        end else begin
          state_nxt = lrfe_pkg::S_EASE_INIT;
        end
      end
      lrfe_pkg::S_LV_NUM: state_nxt = lrfe_pkg::S_LV_SCL;
      lrfe_pkg::S_LV_SCL: state_nxt = lrfe_pkg::S_LV_DIV;
      lrfe_pkg::S_LV_DIV: state_nxt = lrfe_pkg::S_LV_WB;
      lrfe_pkg::S_LV_WB: begin
        // An init item draws the start level first, then the target level.
        if (pass_from_r) begin
          pass_from_nxt = 1'b0;
          state_nxt     = lrfe_pkg::S_LV_NUM;
        end else begin
          state_nxt = lrfe_pkg::S_UPDATE;
        end
      end
      lrfe_pkg::S_UPDATE: state_nxt = lrfe_pkg::S_EASE_INIT;
      lrfe_pkg::S_EASE_INIT: begin
        cnt_nxt   = '0;
        state_nxt = lrfe_pkg::S_EASE_DIV;
      end
      lrfe_pkg::S_EASE_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lrfe_pkg::CNT_W'(lrfe_pkg::EASE_Q_W - 1)) state_nxt = lrfe_pkg::S_COS1;
      end
      lrfe_pkg::S_COS1: state_nxt = lrfe_pkg::S_COS2;
      lrfe_pkg::S_COS2: state_nxt = lrfe_pkg::S_MIX1;
      lrfe_pkg::S_MIX1: state_nxt = lrfe_pkg::S_MIX2;
      lrfe_pkg::S_MIX2: state_nxt = lrfe_pkg::S_DONE;
      lrfe_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = lrfe_pkg::S_IDLE;
      end
      default: state_nxt = lrfe_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      lrfe_pkg::S_IDLE:      cmd.load = in_valid;
      lrfe_pkg::S_READ:      cmd.rec_load = 1'b1;
      lrfe_pkg::S_CHECK: begin
        cmd.zero_res = !status.idx_ok;
        cmd.take_to  = status.idx_ok && !status.is_init && status.expired;
      end
      lrfe_pkg::S_LV_NUM: begin
        cmd.lv_num  = 1'b1;
        cmd.lv_from = pass_from_r;
      end
      lrfe_pkg::S_LV_SCL:    cmd.lv_scl = 1'b1;
      lrfe_pkg::S_LV_DIV:    cmd.lv_div = 1'b1;
      lrfe_pkg::S_LV_WB: begin
        cmd.lv_wb   = 1'b1;
        cmd.lv_from = pass_from_r;
      end
      lrfe_pkg::S_UPDATE:    cmd.update = 1'b1;
      lrfe_pkg::S_EASE_INIT: cmd.ease_init = 1'b1;
      lrfe_pkg::S_EASE_DIV:  cmd.ease_div = 1'b1;
      lrfe_pkg::S_COS1:      cmd.cos1 = 1'b1;
      lrfe_pkg::S_COS2:      cmd.cos2 = 1'b1;
      lrfe_pkg::S_MIX1:      cmd.mix1 = 1'b1;
      lrfe_pkg::S_MIX2:      cmd.mix2 = 1'b1;
      lrfe_pkg::S_DONE:      cmd.out_load = !out_valid_r || !out_stall;
      default:               cmd = '0;
    endcase
  end

  // A new result may load in the same cycle as the previous one transfers.
  assign out_valid_nxt = (out_valid_r && out_stall) || cmd.out_load;

  assign in_stall  = (state_r != lrfe_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/lrfe_dp.sv]
// Datapath of the LED fade engine: configuration, LED record memory, draws and easing.
module lrfe_dp #(
  parameter int LED_COUNT = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lrfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_wdata,
  input  logic                              in_operation,
  input  logic [5:0]                        in_led_index,
  input  logic [31:0]                       in_now_ms,
  input  logic [13:0]                       in_rand_fraction,
  input  logic [13:0]                       in_rand_fraction_start,
  input  logic [15:0]                       in_rand_duration,
  input  logic [15:0]                       in_rand_phase,
  input  lrfe_pkg::ctrl_cmd_t               cmd,
  output lrfe_pkg::dp_status_t              status,
  output logic [7:0]                        out_brightness
);

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Configuration registers.
  logic [7:0]  ceil_r;
  logic [9:0]  lo_r, hi_r;
  logic [15:0] dmin_r, dmax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= lrfe_pkg::RST_CEILING;
      lo_r   <= lrfe_pkg::RST_LEVEL_LOW;
      hi_r   <= lrfe_pkg::RST_LEVEL_HIGH;
      dmin_r <= lrfe_pkg::RST_DUR_MIN;
      dmax_r <= lrfe_pkg::RST_DUR_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrfe_pkg::CFG_CEILING:    ceil_r <= cfg_wdata[7:0];
        lrfe_pkg::CFG_LEVEL_LOW:  lo_r   <= cfg_wdata[9:0];
        lrfe_pkg::CFG_LEVEL_HIGH: hi_r   <= cfg_wdata[9:0];
        lrfe_pkg::CFG_DUR_MIN:    dmin_r <= cfg_wdata;
        lrfe_pkg::CFG_DUR_MAX:    dmax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Item capture and working registers.
  logic                op_r, idx_ok_r;
  logic [AW-1:0]       addr_r;
  logic [31:0]         now_r;
  logic [13:0]         rf_r, rfs_r;
  logic [15:0]         rd_r, rp_r;
  lrfe_pkg::led_rec_t  mem [LED_COUNT];
  lrfe_pkg::led_rec_t  rec_rd_r;
  logic [7:0]          from_r, to_r;
  logic [31:0]         start_r;
  logic [15:0]         len_r;
  logic [23:0]         num_r;
  logic [24:0]         lscaled_r;
  logic [50:0]         lprod_r;
  logic [16:0]         erem_r, eq_r;
  logic                len_zero_r;
  logic [16:0]         a_r;
  logic [23:0]         dp_r;
  logic                upper_r;
  logic [16:0]         e_r;
  logic [24:0]         p1_r;
  logic [7:0]          res_r, out_r;

  logic [AW-1:0]       addr_in;
  logic                idx_ok_in;
  assign addr_in   = AW'(in_led_index);
  assign idx_ok_in = ({26'b0, in_led_index} < 32'(LED_COUNT));

  // Level draw: low*10000 + f*(high-low), scaled by the ceiling and rounded.
  logic [9:0]          lo_sat, hi_sat;
  logic [13:0]         frac_sel, f_sat;
  logic signed [10:0]  diff_s;
  logic signed [25:0]  fprod_s;
  logic [23:0]         lo_scaled;
  logic signed [26:0]  num_s;
  logic [31:0]         lvl_val;
  logic [7:0]          lvl_q;

  assign lo_sat    = (lo_r > lrfe_pkg::PERMILLE_MAX) ? lrfe_pkg::PERMILLE_MAX : lo_r;
  assign hi_sat    = (hi_r > lrfe_pkg::PERMILLE_MAX) ? lrfe_pkg::PERMILLE_MAX : hi_r;
  assign frac_sel  = cmd.lv_from ? rfs_r : rf_r;
  assign f_sat     = (frac_sel > lrfe_pkg::FRAC_MAX) ? lrfe_pkg::FRAC_MAX : frac_sel;
  assign diff_s    = $signed({1'b0, hi_sat}) - $signed({1'b0, lo_sat});
  assign fprod_s   = $signed({1'b0, f_sat}) * diff_s;
  assign lo_scaled = {14'b0, lo_sat} * lrfe_pkg::LVL_SCALE;
  assign num_s     = $signed({3'b0, lo_scaled}) + 27'(fprod_s);
  assign lvl_val   = {8'b0, num_r} * {24'b0, ceil_r} + lrfe_pkg::LVL_ROUND;
  // The quotient never exceeds 255, so eight bits above the shift hold it exactly.
  assign lvl_q     = lprod_r[lrfe_pkg::LVL_RCP_SH +: 8];

  // Duration and start time of a fresh fade.
  logic [15:0] span, rd_sat, dur_new, lim, ph_sat;
  logic [31:0] start_new;

  assign span      = (dmax_r >= dmin_r) ? (dmax_r - dmin_r) : 16'd0;
  assign rd_sat    = (rd_r > span) ? span : rd_r;
  assign dur_new   = dmin_r + rd_sat;
  assign lim       = (dmax_r == 16'd0) ? 16'd0 : (dmax_r - 16'd1);
  assign ph_sat    = (rp_r > lim) ? lim : rp_r;
  assign start_new = (op_r == lrfe_pkg::OP_INIT) ? (now_r - {16'b0, ph_sat}) : now_r;

  // Elapsed by length as a Q1.16 fraction, one quotient bit per cycle.
  logic [31:0] elapsed;
  logic [15:0] t_clamp;
  logic        ege;
  logic [16:0] ediff;

  assign elapsed = now_r - start_r;
  assign t_clamp = (elapsed > {16'b0, len_r}) ? len_r : elapsed[15:0];
  assign ege     = (erem_r >= {1'b0, len_r});
  assign ediff   = ege ? (erem_r - {1'b0, len_r}) : erem_r;

  // Cosine lookup with linear interpolation, mirrored over the second half.
  logic [16:0] xq, yq, ca, cb, cdiff, cval;
  logic [4:0]  cidx;
  logic [10:0] cfr;
  logic        upper;
  logic [17:0] esum;
  logic [24:0] msum;

  assign xq    = len_zero_r ? lrfe_pkg::Q16_ONE : eq_r;
  assign upper = (xq > lrfe_pkg::Q16_HALF);
  assign yq    = upper ? (lrfe_pkg::Q16_ONE - xq) : xq;
  assign cidx  = yq[15:11];
  assign cfr   = yq[10:0];
  assign ca    = lrfe_pkg::cos_tab(cidx);
  assign cb    = lrfe_pkg::cos_tab(cidx + 5'd1);
  assign cdiff = ca - cb;
  assign cval  = a_r - 17'(dp_r >> 11);
  assign esum  = upper_r ? ({1'b0, lrfe_pkg::Q16_ONE} + {1'b0, cval})
                         : ({1'b0, lrfe_pkg::Q16_ONE} - {1'b0, cval});
  assign msum  = p1_r + 25'(e_r) * 25'(to_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      idx_ok_r <= idx_ok_in;
      addr_r   <= addr_in;
      now_r    <= in_now_ms;
      rf_r     <= in_rand_fraction;
      rfs_r    <= in_rand_fraction_start;
      rd_r     <= in_rand_duration;
      rp_r     <= in_rand_phase;
      rec_rd_r <= mem[addr_in];
    end
    if (cmd.rec_load) begin
      from_r  <= rec_rd_r.from_level;
      to_r    <= rec_rd_r.to_level;
      start_r <= rec_rd_r.fade_start_ms;
      len_r   <= rec_rd_r.fade_length_ms;
    end
    if (cmd.take_to) from_r <= to_r;
    if (cmd.lv_num) num_r <= num_s[23:0];
    if (cmd.lv_scl) lscaled_r <= lvl_val[31:lrfe_pkg::LVL_PRE_SH];
    if (cmd.lv_div) lprod_r <= 51'(lscaled_r) * 51'(lrfe_pkg::LVL_RCP);
    if (cmd.lv_wb) begin
      if (cmd.lv_from) from_r <= lvl_q;
      else             to_r   <= lvl_q;
    end
    if (cmd.update) begin
      len_r   <= dur_new;
      start_r <= start_new;
    end
    if (cmd.ease_init) begin
      if (idx_ok_r) mem[addr_r] <= '{from_r, to_r, start_r, len_r};
      erem_r     <= {1'b0, t_clamp};
      eq_r       <= '0;
      len_zero_r <= (len_r == 16'd0);
    end
    if (cmd.ease_div) begin
      erem_r <= {ediff[15:0], 1'b0};
      eq_r   <= {eq_r[15:0], ege};
    end
    if (cmd.cos1) begin
      a_r     <= ca;
      dp_r    <= 24'(cdiff) * 24'(cfr);
      upper_r <= upper;
    end
    if (cmd.cos2) e_r <= esum[17:1];
    if (cmd.mix1) p1_r <= 25'(lrfe_pkg::Q16_ONE - e_r) * 25'(from_r);
    if (cmd.mix2) res_r <= msum[24] ? 8'hFF : msum[23:16];
    if (cmd.zero_res) res_r <= '0;
    if (cmd.out_load) out_r <= res_r;
  end

  assign status.idx_ok  = idx_ok_r;
  assign status.is_init = (op_r == lrfe_pkg::OP_INIT);
  assign status.expired = (elapsed >= {16'b0, len_r});

  assign out_brightness = out_r;

endmodule
